[sv/i2c_master_bit_sequencer_assert.svh]
// Assertion macros used by the sequencer's skid buffer.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define I2CMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("i2cms assertion failed");

// Check that a condition is followed by another in the next cycle.
`define I2CMS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("i2cms assertion failed");

`endif

[sv/i2cms_pkg.sv]
// Types, codes and timing tables of the I2C master bit sequencer.
package i2cms_pkg;

    localparam int BYTE_BITS = 8;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_WAIT  = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_ST_C = 5'd3,
        PH_ST_D = 5'd4,
        PH_SP_A = 5'd5,
        PH_SP_B = 5'd6,
        PH_SP_C = 5'd7,
        PH_WR_A = 5'd8,
        PH_WR_B = 5'd9,
        PH_WR_C = 5'd10,
        PH_WR_D = 5'd11,
        PH_WA_A = 5'd12,
        PH_WA_B = 5'd13,
        PH_WA_P = 5'd14,
        PH_RD_A = 5'd15,
        PH_RD_B = 5'd16,
        PH_RD_C = 5'd17,
        PH_AK_A = 5'd18,
        PH_AK_B = 5'd19,
        PH_AK_C = 5'd20
    } t_phase;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driving;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_res;

    // Ticks spent in each segment.
    function automatic logic [2:0] seg_len(input t_phase ph);
        logic [2:0] len;
        case (ph)
            PH_IDLE: len = 3'd1;
            PH_ST_A: len = 3'd2;
            PH_ST_B: len = 3'd5;
            PH_ST_C: len = 3'd4;
            PH_ST_D: len = 3'd2;
            PH_SP_A: len = 3'd2;
            PH_SP_B: len = 3'd5;
            PH_SP_C: len = 3'd4;
            PH_WR_A: len = 3'd2;
            PH_WR_B: len = 3'd4;
            PH_WR_C: len = 3'd2;
            PH_WR_D: len = 3'd2;
            PH_WA_A: len = 3'd2;
            PH_WA_B: len = 3'd2;
            PH_WA_P: len = 3'd1;
            PH_RD_A: len = 3'd5;
            PH_RD_B: len = 3'd2;
            PH_RD_C: len = 3'd2;
            PH_AK_A: len = 3'd2;
            PH_AK_B: len = 3'd4;
            PH_AK_C: len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

[sv/i2cms_cmd_if.sv]
// Command channel: one tick word with optional command and sampled SDA.
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, cmd_valid, op, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, cmd_valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

[sv/i2cms_res_if.sv]
// Result channel: pin levels and status for one tick.
interface i2cms_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_driving;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;

    modport source (output valid, scl_level, sda_level, sda_driving, busy_res, done_res,
                    rx_byte, ack_failed, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_driving, busy_res, done_res,
                    rx_byte, ack_failed, output ready);
endinterface

[sv/i2cms_core.sv]
// Sequencer state and one-tick next-state and result logic.
module i2cms_core
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_fire,
    input  logic       i_cmd_valid,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    output t_res       o_res
);

    logic [7:0] r_ack_timeout;
    t_phase     r_phase,   n_phase;
    logic [2:0] r_wait,    n_wait;
    logic [3:0] r_bit,     n_bit;
    logic [7:0] r_shift,   n_shift;
    logic [7:0] r_tcount,  n_tcount;
    logic       r_ack_sel, n_ack_sel;
    logic       r_scl,     n_scl;
    logic       r_sda,     n_sda;
    logic       r_drv,     n_drv;
    logic [7:0] r_rx,      n_rx;
    logic       r_fail,    n_fail;

    always_comb begin
        logic busy;
        logic done;
        n_phase   = r_phase;
        n_wait    = r_wait;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_tcount  = r_tcount;
        n_ack_sel = r_ack_sel;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drv     = r_drv;
        n_rx      = r_rx;
        n_fail    = r_fail;
        busy      = 1'b0;
        done      = 1'b0;

        // Take a new command only while idle; bad op codes are dropped.
        if (r_phase == PH_IDLE && i_cmd_valid && (i_op inside {[OP_START:OP_READ]})) begin
            n_shift   = (i_op == OP_WRITE) ? i_tx_byte : 8'd0;
            n_ack_sel = i_send_ack;
            n_bit     = 4'd0;
            n_tcount  = 8'd0;
            n_wait    = 3'd0;
            case (i_op)
                OP_START: n_phase = PH_ST_A;
                OP_STOP:  n_phase = PH_SP_A;
                OP_WRITE: n_phase = PH_WR_A;
                OP_WAIT:  n_phase = PH_WA_A;
                OP_READ:  n_phase = PH_RD_A;
                default:  n_phase = PH_IDLE;
            endcase
        end

        if (n_phase != PH_IDLE) begin
            busy = 1'b1;
            if (n_phase == PH_WA_P) begin
                if (!i_sda_in) begin
                    n_scl   = 1'b0;
                    n_fail  = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else begin
                    if (n_tcount != 8'hFF) n_tcount = n_tcount + 8'd1;
                    // Timed out: run a stop with SCL still high.
                    if (n_tcount >= r_ack_timeout) begin
                        n_fail  = 1'b1;
                        n_phase = PH_SP_A;
                        n_wait  = 3'd0;
                    end
                end
            end else begin
                // Set the pins on the first tick of a segment.
                if (n_wait == 3'd0) begin
                    case (n_phase)
                        PH_ST_A: begin n_drv = 1'b1; n_sda = 1'b1; end
                        PH_ST_B: n_scl = 1'b1;
                        PH_ST_C: n_sda = 1'b0;
                        PH_ST_D: n_scl = 1'b0;
                        PH_SP_A: begin n_drv = 1'b1; n_sda = 1'b0; end
                        PH_SP_B: n_scl = 1'b1;
                        PH_SP_C: n_sda = 1'b1;
                        PH_WR_A: begin n_drv = 1'b1; n_sda = n_shift[BYTE_BITS-1]; end
                        PH_WR_B: n_scl = 1'b1;
                        PH_WR_C: n_scl = 1'b0;
                        PH_WR_D: n_scl = 1'b0;
                        PH_WA_A: begin n_drv = 1'b0; n_sda = 1'b1; end
                        PH_WA_B: n_scl = 1'b1;
                        PH_RD_A: begin n_drv = 1'b0; n_scl = 1'b0; end
                        PH_RD_B: n_scl = 1'b1;
                        PH_RD_C: n_shift = {n_shift[BYTE_BITS-2:0], i_sda_in};
                        PH_AK_A: begin
                            n_scl = 1'b0;
                            n_drv = 1'b1;
                            n_sda = ~n_ack_sel;
                        end
                        PH_AK_B: n_scl = 1'b1;
                        PH_AK_C: n_scl = 1'b0;
                        default: ;
                    endcase
                end
                n_wait = n_wait + 3'd1;
                if (n_wait >= seg_len(n_phase)) begin
                    n_wait = 3'd0;
                    case (n_phase)
                        PH_ST_A: n_phase = PH_ST_B;
                        PH_ST_B: n_phase = PH_ST_C;
                        PH_ST_C: n_phase = PH_ST_D;
                        PH_SP_A: n_phase = PH_SP_B;
                        PH_SP_B: n_phase = PH_SP_C;
                        PH_WR_A: n_phase = PH_WR_B;
                        PH_WR_B: n_phase = PH_WR_C;
                        PH_WR_C: begin
                            n_shift = {n_shift[BYTE_BITS-2:0], 1'b0};
                            n_bit   = n_bit + 4'd1;
                            n_phase = (n_bit < 4'(BYTE_BITS)) ? PH_WR_A : PH_WR_D;
                        end
                        PH_WA_A: n_phase = PH_WA_B;
                        PH_WA_B: n_phase = PH_WA_P;
                        PH_RD_A: n_phase = PH_RD_B;
                        PH_RD_B: n_phase = PH_RD_C;
                        PH_RD_C: begin
                            n_bit = n_bit + 4'd1;
                            if (n_bit < 4'(BYTE_BITS)) begin
                                n_phase = PH_RD_A;
                            end else begin
                                n_rx    = n_shift;
                                n_phase = PH_AK_A;
                            end
                        end
                        PH_AK_A: n_phase = PH_AK_B;
                        PH_AK_B: n_phase = PH_AK_C;
                        default: n_phase = PH_IDLE;
                    endcase
                    if (n_phase == PH_IDLE) done = 1'b1;
                end
            end
        end

        o_res.scl_level   = n_scl;
        o_res.sda_level   = n_sda;
        o_res.sda_driving = n_drv;
        o_res.busy_res    = busy;
        o_res.done_res    = done;
        o_res.rx_byte     = n_rx;
        o_res.ack_failed  = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RESET;
            r_phase       <= PH_IDLE;
            r_wait        <= 3'd0;
            r_bit         <= 4'd0;
            r_shift       <= 8'd0;
            r_tcount      <= 8'd0;
            r_ack_sel     <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_drv         <= 1'b1;
            r_rx          <= 8'd0;
            r_fail        <= 1'b0;
        end else begin
            if (i_cfg_we) r_ack_timeout <= i_cfg_wdata;
            if (i_fire) begin
                r_phase   <= n_phase;
                r_wait    <= n_wait;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_tcount  <= n_tcount;
                r_ack_sel <= n_ack_sel;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_drv     <= n_drv;
                r_rx      <= n_rx;
                r_fail    <= n_fail;
            end
        end
    end

endmodule

[sv/i2cms_skid.sv]
// Two-entry result buffer: output register plus skid register.
`include "i2c_master_bit_sequencer_assert.svh"

module i2cms_skid
    import i2cms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    output logic o_ready,
    output logic o_valid,
    input  logic i_take,
    output t_res o_data
);

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic take;

    assign take    = r_out_valid && i_take;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Advance the parked word once the output is taken.
            if (take) r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (r_out_valid && !take) r_skid_valid <= 1'b1;
            else r_out_valid <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) r_out <= r_skid;
        end else if (i_push) begin
            if (r_out_valid && !take) r_skid <= i_data;
            else r_out <= i_data;
        end
    end

    `I2CMS_ASSERT(a_skid_behind_out, !r_skid_valid || r_out_valid)
    `I2CMS_ASSERT_NEXT(a_stall_parks, i_push && r_out_valid && !i_take, r_skid_valid)
    `I2CMS_ASSERT_NEXT(a_skid_advances, r_skid_valid && i_take,
                       !r_skid_valid && r_out_valid && (r_out == $past(r_skid)))

endmodule

[sv/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer.
//
//  channel  | dir | handshake   | word
//  ---------+-----+-------------+---------------------------------------------
//  i_cmd    | in  | valid/ready | cmd_valid, op, tx_byte, send_ack, sda_in
//  o_res    | out | valid/ready | scl/sda levels, sda_driving, busy, done, rx, fail
//  cfg      | in  | we only     | ack timeout ticks, 8 bits
//
// One tick word is accepted per cycle while input ready is high; its result is registered in the buffer.
// The sequencer state and pin latches step in the core on each accepted word.
// Reset (synchronous, active low) idles the sequencer with SCL and SDA high and driven.
// A stalled result parks in a skid register; input ready drops only when both fill.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    i2cms_cmd_if.sink  i_cmd,
    i2cms_res_if.source o_res
);

    logic fire;
    logic in_ready;
    t_res core_res;
    t_res out_res;

    assign i_cmd.ready = in_ready;
    assign fire        = i_cmd.valid && in_ready;

    i2cms_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_cmd_valid (i_cmd.cmd_valid),
        .i_op        (i_cmd.op),
        .i_tx_byte   (i_cmd.tx_byte),
        .i_send_ack  (i_cmd.send_ack),
        .i_sda_in    (i_cmd.sda_in),
        .o_res       (core_res)
    );

    i2cms_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (core_res),
        .o_ready (in_ready),
        .o_valid (o_res.valid),
        .i_take  (o_res.ready),
        .o_data  (out_res)
    );

    assign o_res.scl_level   = out_res.scl_level;
    assign o_res.sda_level   = out_res.sda_level;
    assign o_res.sda_driving = out_res.sda_driving;
    assign o_res.busy_res    = out_res.busy_res;
    assign o_res.done_res    = out_res.done_res;
    assign o_res.rx_byte     = out_res.rx_byte;
    assign o_res.ack_failed  = out_res.ack_failed;

endmodule

[verif/i2cms_checker.sv]
// Scoreboard for the I2C master bit sequencer: per-tick pin predictor and result compare.
module i2cms_checker
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    i2cms_cmd_if       i_cmd,
    i2cms_res_if       i_res,
    output int         o_fail_count,
    output int         o_pending
);

    t_phase     seq_ph;
    logic [2:0] hold_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] poll_cnt;
    logic [7:0] ack_timeout;
    logic       ack_sel;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    logic [7:0] rx_last;
    logic       ack_fail_q;
    t_res       pin_status_q[$];
    int         res_idx;

    function automatic int segment_ticks(input t_phase ph);
        case (ph)
            PH_ST_B, PH_SP_B, PH_RD_A: return 5;
            PH_ST_C, PH_SP_C, PH_WR_B, PH_AK_B: return 4;
            PH_WA_P: return 1;
            default: return 2;
        endcase
    endfunction

    // Advance the sequencer by one tick and return the pins and status it shows.
    task automatic step_tick(input logic cv, input logic [2:0] op, input logic [7:0] txb,
                             input logic sack, input logic sdi, output t_res r);
        logic busy;
        logic done;
        busy = 1'b0;
        done = 1'b0;

        if (seq_ph == PH_IDLE && cv && int'(op) <= int'(OP_READ)) begin
            shreg    = (op == OP_WRITE) ? txb : 8'h00;
            ack_sel  = sack;
            bit_cnt  = 4'd0;
            poll_cnt = 8'd0;
            hold_cnt = 3'd0;
            case (op)
                OP_START: seq_ph = PH_ST_A;
                OP_STOP:  seq_ph = PH_SP_A;
                OP_WRITE: seq_ph = PH_WR_A;
                OP_WAIT:  seq_ph = PH_WA_A;
                default:  seq_ph = PH_RD_A;
            endcase
        end

        if (seq_ph != PH_IDLE) begin
            busy = 1'b1;
            if (seq_ph == PH_WA_P) begin
                if (!sdi) begin
                    scl_q      = 1'b0;
                    ack_fail_q = 1'b0;
                    seq_ph     = PH_IDLE;
                    done       = 1'b1;
                end else begin
                    if (poll_cnt != 8'hFF) poll_cnt = poll_cnt + 8'd1;
                    // give up: run a stop with SCL still high
                    if (poll_cnt >= ack_timeout) begin
                        ack_fail_q = 1'b1;
                        seq_ph     = PH_SP_A;
                        hold_cnt   = 3'd0;
                    end
                end
            end else begin
                if (hold_cnt == 3'd0) begin
                    case (seq_ph)
                        PH_ST_A: begin drv_q = 1'b1; sda_q = 1'b1; end
                        PH_ST_B: scl_q = 1'b1;
                        PH_ST_C: sda_q = 1'b0;
                        PH_ST_D: scl_q = 1'b0;
                        PH_SP_A: begin drv_q = 1'b1; sda_q = 1'b0; end
                        PH_SP_B: scl_q = 1'b1;
                        PH_SP_C: sda_q = 1'b1;
                        PH_WR_A: begin drv_q = 1'b1; sda_q = shreg[7]; end
                        PH_WR_B: scl_q = 1'b1;
                        PH_WR_C, PH_WR_D: scl_q = 1'b0;
                        PH_WA_A: begin drv_q = 1'b0; sda_q = 1'b1; end
                        PH_WA_B: scl_q = 1'b1;
                        PH_RD_A: begin drv_q = 1'b0; scl_q = 1'b0; end
                        PH_RD_B: scl_q = 1'b1;
                        PH_RD_C: shreg = {shreg[6:0], sdi};
                        PH_AK_A: begin scl_q = 1'b0; drv_q = 1'b1; sda_q = ~ack_sel; end
                        PH_AK_B: scl_q = 1'b1;
                        PH_AK_C: scl_q = 1'b0;
                        default: ;
                    endcase
                end
                hold_cnt = hold_cnt + 3'd1;
                if (int'(hold_cnt) >= segment_ticks(seq_ph)) begin
                    hold_cnt = 3'd0;
                    case (seq_ph)
                        PH_ST_A: seq_ph = PH_ST_B;
                        PH_ST_B: seq_ph = PH_ST_C;
                        PH_ST_C: seq_ph = PH_ST_D;
                        PH_SP_A: seq_ph = PH_SP_B;
                        PH_SP_B: seq_ph = PH_SP_C;
                        PH_WR_A: seq_ph = PH_WR_B;
                        PH_WR_B: seq_ph = PH_WR_C;
                        PH_WR_C: begin
                            shreg   = {shreg[6:0], 1'b0};
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt < BYTE_BITS) seq_ph = PH_WR_A;
                            else seq_ph = PH_WR_D;
                        end
                        PH_WA_A: seq_ph = PH_WA_B;
                        PH_WA_B: seq_ph = PH_WA_P;
                        PH_RD_A: seq_ph = PH_RD_B;
                        PH_RD_B: seq_ph = PH_RD_C;
                        PH_RD_C: begin
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt < BYTE_BITS) begin
                                seq_ph = PH_RD_A;
                            end else begin
                                rx_last = shreg;
                                seq_ph  = PH_AK_A;
                            end
                        end
                        PH_AK_A: seq_ph = PH_AK_B;
                        PH_AK_B: seq_ph = PH_AK_C;
                        default: seq_ph = PH_IDLE;
                    endcase
                    if (seq_ph == PH_IDLE) done = 1'b1;
                end
            end
        end

        r.scl_level   = scl_q;
        r.sda_level   = sda_q;
        r.sda_driving = drv_q;
        r.busy_res    = busy;
        r.done_res    = done;
        r.rx_byte     = rx_last;
        r.ack_failed  = ack_fail_q;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d, %s: got %0h, want %0h", res_idx, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        t_res pred;
        if (!i_rst_n) begin
            seq_ph       = PH_IDLE;
            hold_cnt     = 3'd0;
            bit_cnt      = 4'd0;
            shreg        = 8'h00;
            poll_cnt     = 8'h00;
            ack_timeout  = ACK_TIMEOUT_RESET;
            ack_sel      = 1'b0;
            scl_q        = 1'b1;
            sda_q        = 1'b1;
            drv_q        = 1'b1;
            rx_last      = 8'h00;
            ack_fail_q   = 1'b0;
            res_idx      = 0;
            o_fail_count = 0;
            pin_status_q.delete();
        end else begin
            if (i_cfg_we) ack_timeout = i_cfg_wdata;

            // retire the oldest expectation before adding this edge's word
            if (i_res.valid && i_res.ready) begin
                if (pin_status_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = pin_status_q.pop_front();
                    if (i_res.scl_level !== want.scl_level)
                        report_mismatch("scl_level", i_res.scl_level, want.scl_level);
                    if (i_res.sda_level !== want.sda_level)
                        report_mismatch("sda_level", i_res.sda_level, want.sda_level);
                    if (i_res.sda_driving !== want.sda_driving)
                        report_mismatch("sda_driving", i_res.sda_driving, want.sda_driving);
                    if (i_res.busy_res !== want.busy_res)
                        report_mismatch("busy_res", i_res.busy_res, want.busy_res);
                    if (i_res.done_res !== want.done_res)
                        report_mismatch("done_res", i_res.done_res, want.done_res);
                    if (i_res.rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", i_res.rx_byte, want.rx_byte);
                    if (i_res.ack_failed !== want.ack_failed)
                        report_mismatch("ack_failed", i_res.ack_failed, want.ack_failed);
                end
                res_idx++;
            end

            if (i_cmd.valid && i_cmd.ready) begin
                step_tick(i_cmd.cmd_valid, i_cmd.op, i_cmd.tx_byte, i_cmd.send_ack,
                          i_cmd.sda_in, pred);
                pin_status_q.push_back(pred);
            end
        end
        o_pending <= pin_status_q.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the I2C master bit sequencer: clock, reset, tick stimulus and verdict.
module tb_top;
    import i2cms_pkg::*;

    localparam int RUN_LIMIT   = 4_000_000;
    localparam int PHASES      = 4;
    localparam int PHASE_TICKS = 150;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         fail_count;
    int         pending;
    int         gap_pct;
    int         stall_pct;
    int         noise_pct;
    int         cycle_cnt;
    int         tick_count;
    logic [7:0] timeout_cfg;

    i2cms_cmd_if cmd_if ();
    i2cms_res_if res_if ();

    i2c_master_bit_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_if.sink),
        .o_res       (res_if.source)
    );

    i2cms_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    // Offer one tick word and hold it until it is taken.
    task automatic put_tick(input logic cv, input logic [2:0] op, input logic [7:0] txb,
                            input logic sack, input logic sdi);
        while (int'($urandom_range(99)) < gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd_valid <= cv;
        cmd_if.op        <= op;
        cmd_if.tx_byte   <= txb;
        cmd_if.send_ack  <= sack;
        cmd_if.sda_in    <= sdi;
        do @(posedge i_clk); while (!cmd_if.ready);
        tick_count++;
        @(negedge i_clk);
    endtask

    // Tick while the sequencer is busy; any command offered here is dropped.
    task automatic busy_tick(input logic sdi);
        put_tick(int'($urandom_range(99)) < noise_pct, 3'($urandom_range(7)), 8'($urandom),
                 1'($urandom), sdi);
    endtask

    task automatic busy_ticks(input int n);
        repeat (n) busy_tick(1'($urandom));
    endtask

    // Tick while idle; only unknown op codes are offered.
    task automatic idle_ticks(input int n);
        repeat (n) put_tick($urandom_range(3) == 0, 3'($urandom_range(7, 5)), 8'($urandom),
                            1'($urandom), 1'($urandom));
    endtask

    function automatic int ack_limit();
        return (timeout_cfg == 8'd0) ? 1 : int'(timeout_cfg);
    endfunction

    // Polls with SDA high before the slave acknowledges; at the limit the wait fails.
    function automatic int pick_polls();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85) return $urandom_range(6);
        if (roll < 92) return ack_limit() - 1;
        return ack_limit();
    endfunction

    // Issue one command and tick through exactly the ticks it keeps the sequencer busy.
    task automatic run_cmd(input t_op op, input logic [7:0] txb, input logic sack,
                           input int polls, output logic timed_out);
        int lim;
        lim = ack_limit();
        timed_out = 1'b0;
        put_tick(1'b1, op, txb, sack, 1'($urandom));
        case (op)
            OP_START: busy_ticks(12);
            OP_STOP:  busy_ticks(10);
            OP_WRITE: busy_ticks(65);
            OP_READ:  busy_ticks(79);
            default: begin
                busy_ticks(3);
                repeat ((polls < lim) ? polls : lim) busy_tick(1'b1);
                if (polls < lim) begin
                    busy_tick(1'b0);
                end else begin
                    timed_out = 1'b1;
                    busy_ticks(11);
                end
            end
        endcase
        idle_ticks($urandom_range(2));
    endtask

    // Start, address, then a few writes or reads, then stop; abort on a failed ack.
    task automatic run_transaction();
        logic tmo;
        int   nbytes;
        run_cmd(OP_START, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_WRITE, 8'($urandom), 1'b0, 0, tmo);
        run_cmd(OP_WAIT, 8'h00, 1'b0, pick_polls(), tmo);
        if (tmo) return;
        nbytes = $urandom_range(3, 1);
        if ($urandom_range(1) == 1) begin
            repeat (nbytes) begin
                run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 0, tmo);
                run_cmd(OP_WAIT, 8'($urandom), 1'($urandom), pick_polls(), tmo);
                if (tmo) return;
            end
        end else begin
            for (int k = 0; k < nbytes; k++)
                run_cmd(OP_READ, 8'($urandom), k < nbytes - 1, 0, tmo);
        end
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 0, tmo);
    endtask

    // Drop valid and hold until every word has come back.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        drain();
        repeat (4) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we      <= 1'b0;
        timeout_cfg = v;
    endtask

    initial begin
        logic       tmo;
        logic [7:0] next_cfg;
        int         phase_start;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 8'h00;
        gap_pct          = 0;
        stall_pct        = 0;
        noise_pct        = 10;
        tick_count       = 0;
        timeout_cfg      = ACK_TIMEOUT_RESET;
        cmd_if.valid     = 1'b0;
        cmd_if.cmd_valid = 1'b0;
        cmd_if.op        = 3'd0;
        cmd_if.tx_byte   = 8'h00;
        cmd_if.send_ack  = 1'b0;
        cmd_if.sda_in    = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unknown op codes while idle
        put_tick(1'b1, 3'd5, 8'hFF, 1'b1, 1'b0);
        put_tick(1'b1, 3'd6, 8'h00, 1'b0, 1'b1);
        put_tick(1'b1, 3'd7, 8'hFF, 1'b1, 1'b0);
        run_cmd(OP_START, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_WRITE, 8'hFF, 1'b1, 0, tmo);
        run_cmd(OP_WAIT, 8'hFF, 1'b1, 3, tmo);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, 0, tmo);
        // ack on the last poll, then a timed-out wait
        write_timeout(8'd5);
        run_cmd(OP_WAIT, 8'h00, 1'b0, ack_limit() - 1, tmo);
        run_cmd(OP_WAIT, 8'h00, 1'b0, ack_limit(), tmo);
        run_cmd(OP_START, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_WRITE, 8'h5A, 1'b0, 0, tmo);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_READ, 8'h00, 1'b1, 0, tmo);
        run_cmd(OP_READ, 8'hFF, 1'b0, 0, tmo);
        run_cmd(OP_STOP, 8'h00, 1'b0, 0, tmo);
        // commands offered on every busy tick
        noise_pct = 100;
        run_cmd(OP_WRITE, 8'h3C, 1'b1, 0, tmo);
        run_cmd(OP_READ, 8'hC3, 1'b1, 0, tmo);
        noise_pct = 10;
        run_cmd(OP_STOP, 8'h00, 1'b0, 0, tmo);
        run_cmd(OP_STOP, 8'hFF, 1'b1, 0, tmo);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 1, tmo);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: next_cfg = 8'd1;
                2: next_cfg = 8'd0;
                3: next_cfg = 8'd255;
                default: next_cfg = 8'($urandom_range(254, 2));
            endcase
            write_timeout(next_cfg);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            phase_start = tick_count;
            while (tick_count - phase_start < PHASE_TICKS) begin
                if ($urandom_range(99) < 80)
                    run_transaction();
                else
                    run_cmd(t_op'($urandom_range(4)), 8'($urandom), 1'($urandom),
                            pick_polls(), tmo);
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
